// ===== rtl/box_muller_gaussian_top_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef BOX_MULLER_GAUSSIAN_TOP_ASSERT_SVH
`define BOX_MULLER_GAUSSIAN_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BMG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmg_pkg.sv =====
// shared types, constants and tables of the box-muller gaussian block
`timescale 1ns / 1ps

package bmg_pkg;

    localparam int UNIFORM_BITS_DEF  = 32;
    localparam int OUT_FRAC_BITS_DEF = 16;

    // 2 ln 2 and pi/4 in q.30
    localparam logic [30:0] LN2X2_Q30 = 31'd1488522236;
    localparam logic [29:0] QPI_Q30   = 30'd843314857;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    localparam int LOG_STEPS  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int COS_TERMS  = 5;
    localparam int SIN_TERMS  = 4;
    localparam int DIV_SHIFT  = 34;

    // series divisors (2k+1)(2k+2) for cos and (2k+2)(2k+3) for sin, and floor(2^34 / divisor)
    localparam logic [6:0]  COS_DIV [0:COS_TERMS-1] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
    localparam logic [6:0]  SIN_DIV [0:SIN_TERMS-1] = '{7'd6, 7'd20, 7'd42, 7'd72};
    localparam logic [33:0] COS_RCP [0:COS_TERMS-1] = '{
        34'd8589934592, 34'd1431655765, 34'd572662306, 34'd306783378, 34'd190887435
    };
    localparam logic [33:0] SIN_RCP [0:SIN_TERMS-1] = '{
        34'd2863311530, 34'd858993459, 34'd409044504, 34'd238609294
    };

    // register stages from the input register to the aligned radius and trig values
    localparam int RAD_LAT  = 1 + LOG_STEPS + 3 + SQRT_STEPS;
    localparam int TRIG_LAT = 3 + 3 * COS_TERMS + 1;

    typedef enum logic [0:0] {
        CFG_MEAN_OFFSET = 1'b0,
        CFG_STD_SCALE   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] uniform_radius;
        logic [31:0] uniform_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] gauss_cos;
        logic signed [31:0] gauss_sin;
        logic               zero_clamped;
        logic               saturated;
    } t_out_item;

    // signed cos and sin terms in q.30 after the octant map
    typedef struct packed {
        logic signed [31:0] vc;
        logic signed [31:0] vs;
    } t_trig;

endpackage

// ===== rtl/bmg_radius.sv =====
// radius pipeline: log2 by repeated squaring, scale to -2 ln u, bit-serial square root
`timescale 1ns / 1ps

module bmg_radius #(
    parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_u0,
    output logic [31:0] o_radius
);
    import bmg_pkg::*;

    localparam logic [5:0] UB6 = 6'(UNIFORM_BITS);

    logic [4:0]  w_p0;
    logic [30:0] w_m0;
    logic [4:0]  w_p  [0:LOG_STEPS];
    logic [30:0] w_m  [0:LOG_STEPS];
    logic [29:0] w_fr [0:LOG_STEPS];

    // msb position and normalize into q1.30
    always_comb begin
        w_p0 = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_u0[i]) begin
                w_p0 = 5'(i);
            end
        end
        if (w_p0 == 5'd31) begin
            w_m0 = i_u0[31:1];
        end else begin
            w_m0 = 31'(i_u0 << (5'd30 - w_p0));
        end
    end

    logic [4:0]  r_p0;
    logic [30:0] r_m0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= w_p0;
            r_m0 <= w_m0;
        end
    end

    assign w_p[0]  = r_p0;
    assign w_m[0]  = r_m0;
    assign w_fr[0] = '0;

    // one squaring step per stage, one fraction bit each
    for (genvar i = 0; i < LOG_STEPS; i++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_m2;
        logic [4:0]  r_p;
        logic [30:0] r_m;
        logic [29:0] r_fr;

        assign w_sq = 62'(w_m[i]) * 62'(w_m[i]);
        assign w_m2 = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p <= w_p[i];
                if (w_m2[31]) begin
                    r_m  <= w_m2[31:1];
                    r_fr <= w_fr[i] | (30'd1 << (LOG_STEPS - 1 - i));
                end else begin
                    r_m  <= w_m2[30:0];
                    r_fr <= w_fr[i];
                end
            end
        end

        assign w_p[i+1]  = r_p;
        assign w_m[i+1]  = r_m;
        assign w_fr[i+1] = r_fr;
    end

    // -log2 u split into integer and fraction
    logic [5:0]  r_ip;
    logic [29:0] r_fp;
    logic [36:0] r_ipk;
    logic [60:0] r_fpk;
    logic [36:0] w_s;
    logic [63:0] r_sv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_fr[LOG_STEPS] == '0) begin
                r_ip <= UB6 - {1'b0, w_p[LOG_STEPS]};
                r_fp <= '0;
            end else begin
                r_ip <= UB6 - {1'b0, w_p[LOG_STEPS]} - 6'd1;
                r_fp <= 30'(ONE_Q30 - {1'b0, w_fr[LOG_STEPS]});
            end
            r_ipk <= 37'(r_ip) * 37'(LN2X2_Q30);
            r_fpk <= 61'(r_fp) * 61'(LN2X2_Q30);
            r_sv  <= 64'({w_s, 26'd0});
        end
    end

    assign w_s = r_ipk + 37'(r_fpk[60:30]);

    logic [63:0] w_sv [0:SQRT_STEPS];
    logic [63:0] w_sr [0:SQRT_STEPS];

    assign w_sv[0] = r_sv;
    assign w_sr[0] = '0;

    // restoring square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] w_try;
        logic [63:0] r_v;
        logic [63:0] r_r;

        assign w_try = w_sr[j] + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_sv[j] >= w_try) begin
                    r_v <= w_sv[j] - w_try;
                    r_r <= (w_sr[j] >> 1) + BIT;
                end else begin
                    r_v <= w_sv[j];
                    r_r <= w_sr[j] >> 1;
                end
            end
        end

        assign w_sv[j+1] = r_v;
        assign w_sr[j+1] = r_r;
    end

    assign o_radius = w_sr[SQRT_STEPS][31:0];

endmodule

// ===== rtl/bmg_trig.sv =====
// angle pipeline: octant reduction and taylor series for cos and sin
`timescale 1ns / 1ps

module bmg_trig #(
    parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [31:0]    i_u1,
    output bmg_pkg::t_trig o_trig
);
    import bmg_pkg::*;

    localparam int PH_SHR = (UNIFORM_BITS >= 32) ? UNIFORM_BITS - 32 : 0;
    localparam int PH_SHL = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;

    function automatic logic [30:0] f_mul_x2(input logic [30:0] t, input logic [29:0] x2);
        logic [60:0] pr;
        pr = 61'(t) * 61'(x2);
        return pr[60:30];
    endfunction

    function automatic logic [30:0] f_rcp(input logic [30:0] v, input logic [33:0] m);
        logic [64:0] pr;
        pr = 65'(v) * 65'(m);
        return 31'(pr >> DIV_SHIFT);
    endfunction

    // quotient estimate is low by at most one
    function automatic logic [30:0] f_fix(input logic [30:0] v, input logic [30:0] q0,
                                          input logic [6:0] d);
        logic [30:0] rem;
        rem = v - 31'(q0 * 31'(d));
        return (rem >= 31'(d)) ? q0 + 31'd1 : q0;
    endfunction

    logic [31:0] w_ph;
    logic [29:0] w_res;
    logic [2:0]  r_oct0;
    logic [29:0] r_res;
    logic [59:0] w_xp;
    logic [2:0]  r_oct1;
    logic [29:0] r_x;
    logic [59:0] w_xx;
    logic [2:0]  r_oct2;
    logic [29:0] r_x2;
    logic [29:0] r_xd;

    assign w_ph  = (i_u1 >> PH_SHR) << PH_SHL;
    assign w_res = w_ph[29] ? 30'h2000_0000 - {1'b0, w_ph[28:0]} : {1'b0, w_ph[28:0]};
    assign w_xp  = 60'(r_res) * 60'(QPI_Q30);
    assign w_xx  = 60'(r_x) * 60'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct0 <= w_ph[31:29];
            r_res  <= w_ph[29] ? w_res : {1'b0, w_ph[28:0]};
            r_oct1 <= r_oct0;
            r_x    <= w_xp[58:29];
            r_oct2 <= r_oct1;
            r_x2   <= w_xx[59:30];
            // x held one stage to stay with its own x^2
            r_xd   <= r_x;
        end
    end

    logic [30:0]        w_ct  [0:COS_TERMS];
    logic signed [31:0] w_cs  [0:COS_TERMS];
    logic [29:0]        w_x2  [0:COS_TERMS];
    logic [2:0]         w_oct [0:COS_TERMS];
    logic [30:0]        w_st  [0:SIN_TERMS];
    logic signed [31:0] w_ss  [0:SIN_TERMS];

    assign w_ct[0]  = ONE_Q30;
    assign w_cs[0]  = 32'(ONE_Q30);
    assign w_x2[0]  = r_x2;
    assign w_oct[0] = r_oct2;
    assign w_st[0]  = 31'(r_xd);
    assign w_ss[0]  = 32'(r_xd);

    // cos lane carries x^2 and the octant for both lanes
    for (genvar j = 0; j < COS_TERMS; j++) begin : g_cos
        logic [30:0]        r_av, r_bv, r_bq, r_ct;
        logic signed [31:0] r_as, r_bs, r_cs;
        logic [29:0]        r_ax2, r_bx2, r_cx2;
        logic [2:0]         r_ao, r_bo, r_co;
        logic [30:0]        w_q;

        assign w_q = f_fix(r_bv, r_bq, COS_DIV[j]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_av  <= f_mul_x2(w_ct[j], w_x2[j]);
                r_as  <= w_cs[j];
                r_ax2 <= w_x2[j];
                r_ao  <= w_oct[j];
                r_bq  <= f_rcp(r_av, COS_RCP[j]);
                r_bv  <= r_av;
                r_bs  <= r_as;
                r_bx2 <= r_ax2;
                r_bo  <= r_ao;
                r_ct  <= w_q;
                r_cs  <= ((j % 2) == 0) ? r_bs - $signed({1'b0, w_q})
                                        : r_bs + $signed({1'b0, w_q});
                r_cx2 <= r_bx2;
                r_co  <= r_bo;
            end
        end

        assign w_ct[j+1]  = r_ct;
        assign w_cs[j+1]  = r_cs;
        assign w_x2[j+1]  = r_cx2;
        assign w_oct[j+1] = r_co;
    end

    for (genvar j = 0; j < SIN_TERMS; j++) begin : g_sin
        logic [30:0]        r_av, r_bv, r_bq, r_st;
        logic signed [31:0] r_as, r_bs, r_ss;
        logic [30:0]        w_q;

        assign w_q = f_fix(r_bv, r_bq, SIN_DIV[j]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_av <= f_mul_x2(w_st[j], w_x2[j]);
                r_as <= w_ss[j];
                r_bq <= f_rcp(r_av, SIN_RCP[j]);
                r_bv <= r_av;
                r_bs <= r_as;
                r_st <= w_q;
                r_ss <= ((j % 2) == 0) ? r_bs - $signed({1'b0, w_q})
                                       : r_bs + $signed({1'b0, w_q});
            end
        end

        assign w_st[j+1] = r_st;
        assign w_ss[j+1] = r_ss;
    end

    // sin lane has one term fewer, hold its sum to line up with cos
    logic signed [31:0] r_sd [0:2];
    t_trig              r_trig;
    logic               w_swap;
    logic signed [31:0] w_c;
    logic signed [31:0] w_s;

    assign w_c    = w_cs[COS_TERMS];
    assign w_s    = r_sd[2];
    assign w_swap = w_oct[COS_TERMS][0] ^ w_oct[COS_TERMS][1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= w_ss[SIN_TERMS];
            r_sd[1] <= r_sd[0];
            r_sd[2] <= r_sd[1];
            if (w_oct[COS_TERMS][2] ^ w_oct[COS_TERMS][1]) begin
                r_trig.vc <= w_swap ? -w_s : -w_c;
            end else begin
                r_trig.vc <= w_swap ? w_s : w_c;
            end
            if (w_oct[COS_TERMS][2]) begin
                r_trig.vs <= w_swap ? -w_c : -w_s;
            end else begin
                r_trig.vs <= w_swap ? w_c : w_s;
            end
        end
    end

    assign o_trig = r_trig;

endmodule

// ===== rtl/box_muller_gaussian_top.sv =====
// top level of the box-muller gaussian generator: handshake, alignment and output scaling
`timescale 1ns / 1ps

// Fixed-point Box-Muller generator. Each transaction on the input channel carries two
// uniform fractions and yields one result transaction with r*cos*sigma+mu and
// r*sin*sigma+mu in signed Q16.16 (by default), plus a zero-clamp and a saturation flag.
// The block is fully pipelined: it accepts one transaction per cycle while the output
// is not stalled. The depth comes from the radius path, a 30-stage log2 squaring chain
// followed by a 32-stage bit-serial square root; the cos/sin series runs in parallel
// and is delayed to meet it. When the output stalls the whole pipeline holds, except
// that the input register still fills if empty. The user must write mean_offset and
// std_scale through the configuration port while idle; the block does not enforce it.

`include "box_muller_gaussian_top_assert.svh"

module box_muller_gaussian_top #(
    parameter int UNIFORM_BITS  = bmg_pkg::UNIFORM_BITS_DEF,
    parameter int OUT_FRAC_BITS = bmg_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bmg_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmg_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  bmg_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]         i_cfg_wdata
);
    import bmg_pkg::*;

    localparam logic [31:0] U_MASK =
        (UNIFORM_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam int TRIG_DLY = RAD_LAT - TRIG_LAT;
    localparam int Q_W      = OUT_FRAC_BITS + 13;
    localparam int V_W      = ((Q_W > 32) ? Q_W : 32) + 2;
    localparam logic [56:0] RND = 57'd1 << (43 - OUT_FRAC_BITS);
    localparam logic signed [V_W-1:0] V_MAX = (V_W'(1) << 31) - V_W'(1);
    localparam logic signed [V_W-1:0] V_MIN = -(V_W'(1) << 31);
    localparam logic [31:0] RAIL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RAIL_MIN = 32'h8000_0000;

    // configuration
    logic signed [31:0] r_mean;
    logic [23:0]        r_sigma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_sigma <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MEAN_OFFSET: r_mean  <= i_cfg_wdata;
                CFG_STD_SCALE:   r_sigma <= i_cfg_wdata[23:0];
                default:         r_sigma <= r_sigma;
            endcase
        end
    end

    // pipeline control
    logic                w_adv;
    logic                w_en0;
    logic                r_v0;
    logic [RAD_LAT-1:0]  r_vp;
    logic                r_vf1, r_vf2, r_vf3, r_vf4;
    logic                r_out_vld;

    assign w_adv       = ~r_out_vld | i_out_ready;
    assign w_en0       = w_adv | ~r_v0;
    assign o_in_ready  = w_en0;
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_vp      <= '0;
            r_vf1     <= 1'b0;
            r_vf2     <= 1'b0;
            r_vf3     <= 1'b0;
            r_vf4     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_in_valid;
            end
            if (w_adv) begin
                r_vp      <= {r_vp[RAD_LAT-2:0], r_v0};
                r_vf1     <= r_vp[RAD_LAT-1];
                r_vf2     <= r_vf1;
                r_vf3     <= r_vf2;
                r_vf4     <= r_vf3;
                r_out_vld <= r_vf4;
            end
        end
    end

    // input register: mask unused bits, clamp a zero first sample
    logic [31:0] w_u0m;
    logic [31:0] r_u0;
    logic [31:0] r_u1;
    logic        r_clamp0;

    assign w_u0m = i_in_data.uniform_radius & U_MASK;

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_u0     <= (w_u0m == '0) ? 32'd1 : w_u0m;
            r_clamp0 <= (w_u0m == '0);
            r_u1     <= i_in_data.uniform_angle & U_MASK;
        end
    end

    logic [31:0] w_radius;
    t_trig       w_trig;

    bmg_radius #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_radius (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_u0     (r_u0),
        .o_radius (w_radius)
    );

    bmg_trig #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_trig (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_u1   (r_u1),
        .o_trig (w_trig)
    );

    // line up trig values and the clamp flag with the radius
    t_trig r_td [0:TRIG_DLY-1];
    logic  r_cd [0:RAD_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_td[0] <= w_trig;
            for (int k = 1; k < TRIG_DLY; k++) begin
                r_td[k] <= r_td[k-1];
            end
            r_cd[0] <= r_clamp0;
            for (int k = 1; k < RAD_LAT; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
    end

    // output scaling
    t_trig       w_ta;
    logic [30:0] w_mc, w_ms;
    logic [62:0] r_f1_pc, r_f1_ps;
    logic [1:0]  r_f1_neg, r_f2_neg, r_f3_neg;
    logic        r_f1_cl, r_f2_cl, r_f3_cl, r_f4_cl;
    logic [31:0] r_f2_tc, r_f2_ts;
    logic [55:0] r_f3_pc, r_f3_ps;
    logic [56:0] w_sc, w_ss;
    logic [V_W-1:0]        w_qc, w_qs;
    logic signed [V_W-1:0] w_mu;
    logic signed [V_W-1:0] r_f4_vc, r_f4_vs;
    logic                  w_sat_c, w_sat_s;
    t_out_item             r_out;

    assign w_ta = r_td[TRIG_DLY-1];
    assign w_mc = w_ta.vc[31] ? 31'(-w_ta.vc) : w_ta.vc[30:0];
    assign w_ms = w_ta.vs[31] ? 31'(-w_ta.vs) : w_ta.vs[30:0];

    assign w_sc = 57'(r_f3_pc) + RND;
    assign w_ss = 57'(r_f3_ps) + RND;
    assign w_qc = V_W'(Q_W'(w_sc >> (44 - OUT_FRAC_BITS)));
    assign w_qs = V_W'(Q_W'(w_ss >> (44 - OUT_FRAC_BITS)));
    assign w_mu = V_W'(r_mean);

    assign w_sat_c = (r_f4_vc > V_MAX) || (r_f4_vc < V_MIN);
    assign w_sat_s = (r_f4_vs > V_MAX) || (r_f4_vs < V_MIN);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_pc  <= 63'(w_radius) * 63'(w_mc);
            r_f1_ps  <= 63'(w_radius) * 63'(w_ms);
            r_f1_neg <= {w_ta.vc[31], w_ta.vs[31]};
            r_f1_cl  <= r_cd[RAD_LAT-1];

            r_f2_tc  <= 32'((64'(r_f1_pc) + (64'd1 << 29)) >> 30);
            r_f2_ts  <= 32'((64'(r_f1_ps) + (64'd1 << 29)) >> 30);
            r_f2_neg <= r_f1_neg;
            r_f2_cl  <= r_f1_cl;

            r_f3_pc  <= 56'(r_f2_tc) * 56'(r_sigma);
            r_f3_ps  <= 56'(r_f2_ts) * 56'(r_sigma);
            r_f3_neg <= r_f2_neg;
            r_f3_cl  <= r_f2_cl;

            r_f4_vc  <= (r_f3_neg[1] ? -$signed(w_qc) : $signed(w_qc)) + w_mu;
            r_f4_vs  <= (r_f3_neg[0] ? -$signed(w_qs) : $signed(w_qs)) + w_mu;
            r_f4_cl  <= r_f3_cl;

            r_out.gauss_cos    <= w_sat_c ? (r_f4_vc[V_W-1] ? RAIL_MIN : RAIL_MAX)
                                          : r_f4_vc[31:0];
            r_out.gauss_sin    <= w_sat_s ? (r_f4_vs[V_W-1] ? RAIL_MIN : RAIL_MAX)
                                          : r_f4_vs[31:0];
            r_out.zero_clamped <= r_f4_cl;
            r_out.saturated    <= w_sat_c | w_sat_s;
        end
    end

    assign o_out_data = r_out;

    `BMG_ASSERT_NEXT(a_stall_holds_pipe, i_clk, i_rst_n, !w_adv, $stable(r_vp), "valid bits moved while the output was stalled")
    `BMG_ASSERT_NOW(a_out_from_last_stage, i_clk, i_rst_n, $rose(r_out_vld), $past(r_vf4), "result appeared without a valid item in the last scaling stage")
    `BMG_ASSERT_NOW(a_sat_on_rail, i_clk, i_rst_n, r_out_vld && r_out.saturated, r_out.gauss_cos == RAIL_MAX || r_out.gauss_cos == RAIL_MIN || r_out.gauss_sin == RAIL_MAX || r_out.gauss_sin == RAIL_MIN, "saturation flagged but no output at a rail")

endmodule
